FILE: sv/ght_pkg.sv
// Shared types, constants and helper functions for the generational handle table.
// No dependencies; used by every module of the block.
package ght_pkg;

   // Storage geometry
   localparam int QUEUE_DEPTH = 1024;
   localparam int QUEUE_AW    = 10;
   localparam int SLOT_DEPTH  = QUEUE_DEPTH + 1;
   localparam int SLOT_AW     = 11;
   localparam int CNT_W       = 11;

   // Request kinds
   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;
   localparam logic [1:0] KIND_DELETE = 2'd3;

   // Response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXHAUSTED = 3'd1;
   localparam logic [2:0] ST_OCCUPIED  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_BAD_ID    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW  = 3'd5;

   // Configuration register indexes
   localparam logic CSR_REACTOR_ID = 1'b0;
   localparam logic CSR_MAX_CONN   = 1'b1;

   // Reset value of max_connections
   localparam logic [CNT_W-1:0] MAX_CONN_RESET = 11'd1024;

   // One slot memory entry
   typedef struct packed {
      logic        valid;
      logic [31:0] handle;
      logic [31:0] ctx;
   } slot_entry_type;

   // Control from the sequencer to the free queue
   typedef struct packed {
      logic                init;
      logic                sweep_we;
      logic [QUEUE_AW-1:0] sweep_addr;
      logic [31:0]         sweep_data;
      logic                rd_en;
      logic                pop;
      logic                push;
      logic [31:0]         push_data;
   } queue_ctrl_type;

   // Effective maximum: register value clamped to the queue capacity
   function automatic logic [CNT_W-1:0] eff_max(input logic [CNT_W-1:0] max_conn);
      logic [CNT_W-1:0] cap;
      cap = CNT_W'(QUEUE_DEPTH);
      eff_max = (max_conn > cap) ? cap : max_conn;
   endfunction

   // Index mask B-1, with B the smallest power of two above m
   function automatic logic [CNT_W-1:0] gen_mask(input logic [CNT_W-1:0] m);
      logic [CNT_W-1:0] s;
      s = m;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      gen_mask = s;
   endfunction

endpackage

FILE: sv/ght_free_queue.sv
// Circular free-handle queue: one synchronous memory with head pointer and fill count.
// Depends on ght_pkg for geometry and the queue_ctrl_type control bundle.
module ght_free_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ght_pkg::queue_ctrl_type    ctrl,
   input  logic [ght_pkg::CNT_W-1:0]  init_fill,
   output logic [31:0]                rd_data,
   output logic [ght_pkg::CNT_W-1:0]  fill
);

   logic [31:0]                   mem [ght_pkg::QUEUE_DEPTH];
   logic [31:0]                   rd_data_ff;
   logic [ght_pkg::QUEUE_AW-1:0]  head_ff, head_in;
   logic [ght_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic [ght_pkg::QUEUE_AW-1:0]  tail;

   // Tail position for a requeue
   assign tail = head_ff + fill_ff[ght_pkg::QUEUE_AW-1:0];

   // Advance head and shrink fill on pop, grow fill on push, restart on init
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctrl.init) begin
         head_in = '0;
         fill_in = init_fill;
      end else begin
         if (ctrl.pop) begin
            head_in = head_ff + 1'b1;
         end
         if (ctrl.pop && !ctrl.push) begin
            fill_in = fill_ff - 1'b1;
         end else if (ctrl.push && !ctrl.pop) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Memory write: init sweep or requeue
   always_ff @(posedge clock) begin
      if (ctrl.sweep_we) begin
         mem[ctrl.sweep_addr] <= ctrl.sweep_data;
      end else if (ctrl.push) begin
         mem[tail] <= ctrl.push_data;
      end
   end

   // Registered read at the head
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

FILE: sv/ght_slot_ram.sv
// Slot memory: valid flag, low handle word and context word per slot index.
// Depends on ght_pkg for geometry and slot_entry_type.
module ght_slot_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ght_pkg::SLOT_AW-1:0]   wr_addr,
   input  ght_pkg::slot_entry_type       wr_data,
   input  logic                          rd_en,
   input  logic [ght_pkg::SLOT_AW-1:0]   rd_addr,
   output ght_pkg::slot_entry_type       rd_data
);

   ght_pkg::slot_entry_type mem [ght_pkg::SLOT_DEPTH];
   ght_pkg::slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/generational_handle_table.sv
// Top level of the generational handle table: sequencer, config registers, result register.
// Depends on ght_pkg, ght_free_queue and ght_slot_ram.

// The accept cycle of a request reads the slot memory and the free queue head
// (registered reads), and the next cycle checks, writes back and loads the result
// register. A new request is taken while a result still waits on rsp_ready; a
// request stalls in its evaluate state only if the result register is still full.
// After reset and after every configuration write the block runs an initialization
// sweep over all 1025 slots (one slot per cycle, queue entries below the effective
// maximum) with req_ready low; configuration writes are taken at any time.
module generational_handle_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_conn_id,
   input  logic [31:0] req_context_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_handle_out,
   output logic [31:0] rsp_context_out,
   output logic        rsp_hit,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_SWEEP = 3'b001,
      S_IDLE  = 3'b010,
      S_LOOK  = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [ght_pkg::CNT_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic [15:0]                  reactor_ff, reactor_in;
   logic [ght_pkg::CNT_W-1:0]    max_ff, max_in;
   logic [ght_pkg::CNT_W-1:0]    live_ff, live_in;

   logic [1:0]                   kind_ff;
   logic [63:0]                  cid_ff;
   logic [31:0]                  ctx_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff, status_c;
   logic [63:0]                  rsp_handle_ff, handle_c;
   logic [31:0]                  rsp_context_ff, context_c;
   logic                         rsp_hit_ff, hit_c;

   logic [ght_pkg::CNT_W-1:0]    m_c, mask_c, idx_c, req_idx;
   logic [31:0]                  low_c;
   logic [32:0]                  next_sum;
   logic [31:0]                  next_handle;
   logic                         accept, rsp_free, commit, bad_c, sweep_last;

   ght_pkg::queue_ctrl_type      qctrl;
   logic [31:0]                  q_rd;
   logic [ght_pkg::CNT_W-1:0]    q_fill;

   logic                         slot_we;
   logic [ght_pkg::SLOT_AW-1:0]  slot_waddr;
   ght_pkg::slot_entry_type      slot_wdata, slot_rd;

   // Geometry from configuration
   assign m_c     = ght_pkg::eff_max(max_ff);
   assign mask_c  = ght_pkg::gen_mask(m_c);
   assign req_idx = req_conn_id[ght_pkg::CNT_W-1:0] & mask_c;
   assign low_c   = cid_ff[31:0];
   assign idx_c   = low_c[ght_pkg::CNT_W-1:0] & mask_c;
   assign bad_c   = (cid_ff[63:32] != {16'd0, reactor_ff}) || (idx_c > m_c);

   // Next generation of a deleted handle, bare index on wrap
   assign next_sum    = {1'b0, low_c} + 33'({mask_c} + 12'd1);
   assign next_handle = next_sum[32] ? 32'(idx_c) : next_sum[31:0];

   // Handshake
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign commit     = (state_ff == S_LOOK) && rsp_free;
   assign sweep_last = (sweep_cnt_ff == ght_pkg::CNT_W'(ght_pkg::SLOT_DEPTH - 1));

   // Evaluate the request against the read data
   always_comb begin
      status_c  = ght_pkg::ST_OK;
      handle_c  = cid_ff;
      context_c = '0;
      hit_c     = 1'b0;
      if (kind_ff == ght_pkg::KIND_ALLOC) begin
         if ((live_ff >= m_c) || (q_fill == '0)) begin
            status_c = ght_pkg::ST_EXHAUSTED;
            handle_c = '0;
         end else begin
            handle_c = {16'd0, reactor_ff, q_rd};
         end
      end else if (bad_c) begin
         status_c = ght_pkg::ST_BAD_ID;
      end else begin
         case (kind_ff)
            ght_pkg::KIND_ADD: begin
               if (slot_rd.valid) begin
                  status_c = ght_pkg::ST_OCCUPIED;
                  hit_c    = 1'b1;
               end
            end
            ght_pkg::KIND_LOOKUP: begin
               if (slot_rd.valid && (slot_rd.handle == low_c)) begin
                  hit_c     = 1'b1;
                  context_c = slot_rd.ctx;
               end else begin
                  status_c = ght_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               if (q_fill >= ght_pkg::CNT_W'(ght_pkg::QUEUE_DEPTH)) begin
                  status_c = ght_pkg::ST_OVERFLOW;
               end
               if (slot_rd.valid) begin
                  hit_c     = 1'b1;
                  context_c = slot_rd.ctx;
               end
            end
         endcase
      end
   end

   // Free queue control: sweep fill, head read on accept, pop and requeue on commit
   always_comb begin
      qctrl            = '0;
      qctrl.init       = (state_ff == S_SWEEP) && sweep_last;
      qctrl.sweep_we   = (state_ff == S_SWEEP) && (sweep_cnt_ff < m_c);
      qctrl.sweep_addr = sweep_cnt_ff[ght_pkg::QUEUE_AW-1:0];
      qctrl.sweep_data = 32'(sweep_cnt_ff) + 32'd1;
      qctrl.rd_en      = accept;
      qctrl.pop        = commit && (kind_ff == ght_pkg::KIND_ALLOC)
                         && (status_c == ght_pkg::ST_OK);
      qctrl.push       = commit && (kind_ff == ght_pkg::KIND_DELETE) && !bad_c
                         && (status_c != ght_pkg::ST_OVERFLOW);
      qctrl.push_data  = next_handle;
   end

   // Slot write: sweep clear, add into empty slot, delete clear
   always_comb begin
      slot_we           = 1'b0;
      slot_waddr        = idx_c;
      slot_wdata.valid  = 1'b0;
      slot_wdata.handle = low_c;
      slot_wdata.ctx    = ctx_ff;
      if (state_ff == S_SWEEP) begin
         slot_we    = 1'b1;
         slot_waddr = sweep_cnt_ff;
      end else if (commit && !bad_c) begin
         if ((kind_ff == ght_pkg::KIND_ADD) && !slot_rd.valid) begin
            slot_we          = 1'b1;
            slot_wdata.valid = 1'b1;
         end else if (kind_ff == ght_pkg::KIND_DELETE) begin
            slot_we = 1'b1;
         end
      end
   end

   // Sequencer, configuration and live count
   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      reactor_in   = reactor_ff;
      max_in       = max_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (qctrl.pop) begin
                  live_in = live_ff + 1'b1;
               end else if ((kind_ff == ght_pkg::KIND_DELETE) && !bad_c
                            && (live_ff != '0)) begin
                  live_in = live_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
      // Reinitialize on any register write
      if (csr_we) begin
         case (csr_index)
            ght_pkg::CSR_REACTOR_ID: reactor_in = csr_wdata;
            ght_pkg::CSR_MAX_CONN:   max_in     = csr_wdata[ght_pkg::CNT_W-1:0];
            default:                 reactor_in = reactor_ff;
         endcase
         state_in     = S_SWEEP;
         sweep_cnt_in = '0;
         live_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_cnt_ff <= '0;
         reactor_ff   <= '0;
         max_ff       <= ght_pkg::MAX_CONN_RESET;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         reactor_ff   <= reactor_in;
         max_ff       <= max_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         cid_ff  <= req_conn_id;
         ctx_ff  <= req_context_req;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff  <= status_c;
         rsp_handle_ff  <= handle_c;
         rsp_context_ff <= context_c;
         rsp_hit_ff     <= hit_c;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_context_out = rsp_context_ff;
   assign rsp_hit         = rsp_hit_ff;

   ght_free_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (qctrl),
      .init_fill (m_c),
      .rd_data   (q_rd),
      .fill      (q_fill)
   );

   ght_slot_ram u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (slot_rd)
   );

`ifndef SYNTHESIS
   // Free queue never holds more than its capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= ght_pkg::CNT_W'(ght_pkg::QUEUE_DEPTH))
      else $error("free queue fill above capacity");

   // Live count never exceeds the effective maximum
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= ght_pkg::eff_max(max_ff))
      else $error("live count above maximum");

   // An accepted request moves to the evaluate cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_we) |=> (state_ff == S_LOOK))
      else $error("accepted request not evaluated");

   // A stalled evaluation holds until the result register frees
   a_look_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_LOOK) && !rsp_free && !csr_we) |=> (state_ff == S_LOOK))
      else $error("request dropped while result register full");
`endif

endmodule
